FILE: design/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Types, permutation tables, S-boxes and helper functions shared by the
// simplified DES byte cipher. All bit numbering is least significant first.
// ----------------------------------------------------------------------------
`default_nettype none

package sdes_pkg;

    localparam int KEY_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int HALF_W   = 4;
    localparam int SUBKEY_W = 8;

    typedef struct packed {
        logic [SUBKEY_W-1:0] k1;
        logic [SUBKEY_W-1:0] k2;
    } subkeys_t;

    // Output bit i takes input bit SRC[i].
    localparam logic [3:0] P10_SRC [10] = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
                                            4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
    localparam logic [3:0] P8_SRC [8]   = '{4'd5, 4'd2, 4'd6, 4'd3,
                                            4'd7, 4'd4, 4'd9, 4'd8};
    localparam logic [2:0] IP_SRC [8]    = '{3'd1, 3'd5, 3'd2, 3'd0,
                                             3'd3, 3'd7, 3'd4, 3'd6};
    localparam logic [2:0] IPINV_SRC [8] = '{3'd3, 3'd0, 3'd2, 3'd4,
                                             3'd6, 3'd1, 3'd7, 3'd5};
    localparam logic [1:0] EP_SRC [8]    = '{2'd3, 2'd0, 2'd1, 2'd2,
                                             2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [1:0] P4_SRC [4]    = '{2'd1, 2'd3, 2'd2, 2'd0};

    // S-boxes indexed by {row, column}.
    localparam logic [1:0] SBOX0 [16] = '{2'd1, 2'd0, 2'd3, 2'd2,
                                          2'd3, 2'd2, 2'd1, 2'd0,
                                          2'd0, 2'd2, 2'd1, 2'd3,
                                          2'd3, 2'd1, 2'd3, 2'd2};
    localparam logic [1:0] SBOX1 [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                          2'd2, 2'd0, 2'd1, 2'd3,
                                          2'd3, 2'd0, 2'd1, 2'd0,
                                          2'd2, 2'd1, 2'd0, 2'd3};

    function automatic logic [KEY_W-1:0] p10(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < KEY_W; i++) begin
            r[i] = v[P10_SRC[i]];
        end
        return r;
    endfunction

    function automatic logic [SUBKEY_W-1:0] p8(input logic [KEY_W-1:0] v);
        logic [SUBKEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < SUBKEY_W; i++) begin
            r[i] = v[P8_SRC[i]];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] ip(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[IP_SRC[i]];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] ip_inv(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[IPINV_SRC[i]];
        end
        return r;
    endfunction

    function automatic logic [SUBKEY_W-1:0] ep(input logic [HALF_W-1:0] v);
        logic [SUBKEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < SUBKEY_W; i++) begin
            r[i] = v[EP_SRC[i]];
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] p4(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int i = 0; i < HALF_W; i++) begin
            r[i] = v[P4_SRC[i]];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/sdes_block_cipher.sv
// ----------------------------------------------------------------------------
// sdes_block_cipher
// Simplified DES on one byte per transfer, encrypting or decrypting under a
// 10-bit key held as two registered subkeys.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | role
//  s_       | s_valid, s_ready, s_action, s_data_byte | byte and direction in
//  m_       | m_valid, m_ready, m_result_byte         | processed byte out
//  cfg_     | cfg_we, cfg_wdata                       | key write
//
// One transfer is accepted every cycle while s_ready is high; a result is
// presented on m_valid after an input register and a result register.
// The full cipher path sits between those two registers.
// Reset empties both stages and sets both subkeys to zero.
// With m_ready low the result is held, and s_ready falls only when both
// stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module sdes_block_cipher (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [sdes_pkg::KEY_W-1:0]   cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_action,
    input  wire logic [sdes_pkg::BYTE_W-1:0]  s_data_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [sdes_pkg::BYTE_W-1:0]  m_result_byte
);

    sdes_pkg::subkeys_t               subkeys;
    logic                             in_valid_reg;
    logic                             in_action_reg;
    logic [sdes_pkg::BYTE_W-1:0]      in_data_reg;
    logic                             out_valid_reg;
    logic [sdes_pkg::BYTE_W-1:0]      out_data_reg;
    logic [sdes_pkg::BYTE_W-1:0]      out_data_next;
    logic                             advance;
    logic [sdes_pkg::BYTE_W-1:0]      ip_byte;
    logic [sdes_pkg::SUBKEY_W-1:0]    key_a, key_b;
    logic [sdes_pkg::HALF_W-1:0]      f_a, f_b, new_right, fin_left;

    sdes_key_sched u_key_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .subkeys   (subkeys)
    );

    assign ip_byte = sdes_pkg::ip(in_data_reg);
    assign key_a   = in_action_reg ? subkeys.k2 : subkeys.k1;
    assign key_b   = in_action_reg ? subkeys.k1 : subkeys.k2;

    sdes_round u_round_a (
        .half_in (ip_byte[3:0]),
        .subkey  (key_a),
        .f_out   (f_a)
    );

    assign new_right = ip_byte[7:4] ^ f_a;

    sdes_round u_round_b (
        .half_in (new_right),
        .subkey  (key_b),
        .f_out   (f_b)
    );

    assign fin_left      = ip_byte[3:0] ^ f_b;
    assign out_data_next = sdes_pkg::ip_inv({fin_left, new_right});

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_data_reg   <= s_data_byte;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_byte = out_data_reg;

endmodule

`default_nettype wire

FILE: design/sdes_key_sched.sv
// ----------------------------------------------------------------------------
// sdes_key_sched
// Derives both subkeys from a key write and holds them in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sdes_key_sched (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [sdes_pkg::KEY_W-1:0]  cfg_wdata,
    output sdes_pkg::subkeys_t               subkeys
);

    logic [sdes_pkg::KEY_W-1:0] pk;
    logic [4:0]                 lo1, hi1, lo3, hi3;
    sdes_pkg::subkeys_t         subkeys_reg;
    sdes_pkg::subkeys_t         subkeys_next;

    always_comb begin
        pk  = sdes_pkg::p10(cfg_wdata);
        lo1 = {pk[3:0], pk[4]};
        hi1 = {pk[8:5], pk[9]};
        lo3 = {pk[1:0], pk[4:2]};
        hi3 = {pk[6:5], pk[9:7]};
        subkeys_next.k1 = sdes_pkg::p8({hi1, lo1});
        subkeys_next.k2 = sdes_pkg::p8({hi3, lo3});
    end

    // A zero key gives zero subkeys.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subkeys_reg <= '0;
        end else if (cfg_we) begin
            subkeys_reg <= subkeys_next;
        end
    end

    assign subkeys = subkeys_reg;

endmodule

`default_nettype wire

FILE: design/sdes_round.sv
// ----------------------------------------------------------------------------
// sdes_round
// Feistel round function: expansion, subkey mix, two S-boxes and P4.
// ----------------------------------------------------------------------------
`default_nettype none

module sdes_round (
    input  wire logic [sdes_pkg::HALF_W-1:0]   half_in,
    input  wire logic [sdes_pkg::SUBKEY_W-1:0] subkey,
    output logic      [sdes_pkg::HALF_W-1:0]   f_out
);

    logic [sdes_pkg::SUBKEY_W-1:0] x;
    logic [1:0]                    v0, v1;

    always_comb begin
        x     = sdes_pkg::ep(half_in) ^ subkey;
        v0    = sdes_pkg::SBOX0[{x[0], x[3], x[1], x[2]}];
        v1    = sdes_pkg::SBOX1[{x[4], x[7], x[5], x[6]}];
        f_out = sdes_pkg::p4({v1[0], v1[1], v0[0], v0[1]});
    end

endmodule

`default_nettype wire
